>>> hdl/aarm_pkg.sv
// Shared types and constants of the axis-angle rotation matrix block.
package aarm_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sh26DD3B6A;

	localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
		32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
		32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
	};

	typedef struct packed {
		logic [1:0]         quad;
		logic signed [31:0] resid;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [31:0] pxx;
		logic signed [31:0] pyy;
		logic signed [31:0] pzz;
		logic signed [31:0] pxy;
		logic signed [31:0] pxz;
		logic signed [31:0] pyz;
	} item_t;

endpackage

>>> hdl/aarm_front.sv
// Front end: accepts an axis and angle, splits the angle into quadrant and residue
// and forms the axis outer products.
module aarm_front #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  axis_x,
	input  logic signed [15:0]  axis_y,
	input  logic signed [15:0]  axis_z,
	input  logic [15:0]         turn_angle,
	input  logic                push,
	output logic                full,
	output logic                q_push,
	output aarm_pkg::item_t     q_wdata,
	input  logic                q_full
);
	import aarm_pkg::*;

	localparam int ASH = 32 - ANGLE_BITS;
	localparam logic [31:0] AMASK = 32'hFFFF_FFFF >> ASH;

	logic        v_s1;
	item_t       itm_s1;
	item_t       itm_d;
	logic [31:0] turn;
	logic [31:0] t;
	logic        take;

	always_comb begin
		turn = (32'(turn_angle) & AMASK) << ASH;
		t = turn + 32'h2000_0000;
		itm_d.quad = t[31:30];
		itm_d.resid = signed'({2'b00, t[29:0]}) - 32'sh2000_0000;
		itm_d.nx = axis_x;
		itm_d.ny = axis_y;
		itm_d.nz = axis_z;
		itm_d.pxx = 32'(axis_x) * 32'(axis_x);
		itm_d.pyy = 32'(axis_y) * 32'(axis_y);
		itm_d.pzz = 32'(axis_z) * 32'(axis_z);
		itm_d.pxy = 32'(axis_x) * 32'(axis_y);
		itm_d.pxz = 32'(axis_x) * 32'(axis_z);
		itm_d.pyz = 32'(axis_y) * 32'(axis_z);
	end

	assign full = v_s1 && q_full;
	assign take = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_wdata = itm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || !q_full) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			itm_s1 <= itm_d;
		end
	end

endmodule

>>> hdl/aarm_queue.sv
// Short queue that decouples the front end from the back end.
module aarm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aarm_pkg::item_t  wdata,
	output logic             full,
	output logic             rvalid,
	output aarm_pkg::item_t  rdata,
	input  logic             pop
);
	import aarm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && rvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not rise on push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not fall on pop");

endmodule

>>> hdl/aarm_back.sv
// Back end: pipelined CORDIC for sine and cosine, then the Rodrigues matrix entries.
module aarm_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_rvalid,
	input  aarm_pkg::item_t     q_rdata,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic signed [15:0]  m00,
	output logic signed [15:0]  m01,
	output logic signed [15:0]  m02,
	output logic signed [15:0]  m10,
	output logic signed [15:0]  m11,
	output logic signed [15:0]  m12,
	output logic signed [15:0]  m20,
	output logic signed [15:0]  m21,
	output logic signed [15:0]  m22
);
	import aarm_pkg::*;

	localparam int SH = 30 - FRAC_BITS;
	localparam int CS_W = FRAC_BITS + 3;
	localparam int OMC_W = FRAC_BITS + 4;
	localparam int PW = OMC_W + 32;
	localparam int MW = CS_W + 16;
	localparam int AW = PW + 2;
	localparam logic signed [XW:0] HALF_C =
		(SH > 0) ? ((XW+1)'(1) <<< ((SH > 0) ? SH - 1 : 0)) : '0;
	localparam logic signed [AW-1:0] HALF_F = AW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
	localparam logic signed [AW-1:0] SAT_MIN = -AW'(32768);
	localparam logic signed [OMC_W-1:0] ONE = OMC_W'(1) <<< FRAC_BITS;

	logic                  en;
	logic                  cv_q   [CORDIC_STEPS+1];
	logic signed [XW-1:0]  cx_q   [CORDIC_STEPS+1];
	logic signed [XW-1:0]  cy_q   [CORDIC_STEPS+1];
	logic signed [ZW-1:0]  cz_q   [CORDIC_STEPS+1];
	item_t                 citm_q [CORDIC_STEPS+1];

	logic                  v_s1;
	logic signed [CS_W-1:0]  c_s1;
	logic signed [CS_W-1:0]  s_s1;
	logic signed [OMC_W-1:0] omc_s1;
	item_t                 itm_s1;

	logic                  v_s2;
	logic signed [CS_W-1:0] c_s2;
	logic signed [PW-1:0]  mxx_s2, myy_s2, mzz_s2, mxy_s2, mxz_s2, myz_s2;
	logic signed [MW-1:0]  msx_s2, msy_s2, msz_s2;

	logic                  v_s3;

	logic signed [XW-1:0]  c30;
	logic signed [XW-1:0]  s30;
	logic signed [XW:0]    c_rnd;
	logic signed [XW:0]    s_rnd;
	logic signed [CS_W-1:0] c_d;
	logic signed [AW-1:0]  cone;

	// The whole back end advances together; it halts only while a result waits.
	assign en = !v_s3 || pop;
	assign q_pop = en && q_rvalid;
	assign empty = !v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= 1'b0;
		end else if (en) begin
			cv_q[0] <= q_rvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= XW'(CORDIC_GAIN_INV);
			cy_q[0] <= '0;
			cz_q[0] <= ZW'(q_rdata.resid);
			citm_q[0] <= q_rdata;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[i+1] <= 1'b0;
			end else if (en) begin
				cv_q[i+1] <= cv_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_q[i] >= 0) begin
					cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] - ZW'(ATAN_TURN[i]);
				end else begin
					cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] + ZW'(ATAN_TURN[i]);
				end
				citm_q[i+1] <= citm_q[i];
			end
		end
	end

	always_comb begin
		case (citm_q[CORDIC_STEPS].quad)
			2'd0: begin
				c30 = cx_q[CORDIC_STEPS];
				s30 = cy_q[CORDIC_STEPS];
			end
			2'd1: begin
				c30 = -cy_q[CORDIC_STEPS];
				s30 = cx_q[CORDIC_STEPS];
			end
			2'd2: begin
				c30 = -cx_q[CORDIC_STEPS];
				s30 = -cy_q[CORDIC_STEPS];
			end
			default: begin
				c30 = cy_q[CORDIC_STEPS];
				s30 = -cx_q[CORDIC_STEPS];
			end
		endcase
		c_rnd = ((XW+1)'(c30) + HALF_C) >>> SH;
		s_rnd = ((XW+1)'(s30) + HALF_C) >>> SH;
		c_d = CS_W'(c_rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= cv_q[CORDIC_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c_d;
			s_s1 <= CS_W'(s_rnd);
			omc_s1 <= ONE - OMC_W'(c_d);
			itm_s1 <= citm_q[CORDIC_STEPS];

			c_s2 <= c_s1;
			mxx_s2 <= PW'(omc_s1) * PW'(itm_s1.pxx);
			myy_s2 <= PW'(omc_s1) * PW'(itm_s1.pyy);
			mzz_s2 <= PW'(omc_s1) * PW'(itm_s1.pzz);
			mxy_s2 <= PW'(omc_s1) * PW'(itm_s1.pxy);
			mxz_s2 <= PW'(omc_s1) * PW'(itm_s1.pxz);
			myz_s2 <= PW'(omc_s1) * PW'(itm_s1.pyz);
			msx_s2 <= MW'(s_s1) * MW'(itm_s1.nx);
			msy_s2 <= MW'(s_s1) * MW'(itm_s1.ny);
			msz_s2 <= MW'(s_s1) * MW'(itm_s1.nz);
		end
	end

	function automatic logic signed [15:0] entry(input logic signed [PW-1:0] mp,
			input logic signed [AW-1:0] add);
		logic signed [AW-1:0] t;
		logic signed [AW-1:0] acc;
		logic signed [AW-1:0] r;
		t = (AW'(mp) + HALF_F) >>> FRAC_BITS;
		acc = t + add;
		r = (acc + HALF_F) >>> FRAC_BITS;
		if (r > SAT_MAX) begin
			r = SAT_MAX;
		end else if (r < SAT_MIN) begin
			r = SAT_MIN;
		end
		return r[15:0];
	endfunction

	assign cone = AW'(c_s2) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			m00 <= entry(mxx_s2, cone);
			m01 <= entry(mxy_s2, -AW'(msz_s2));
			m02 <= entry(mxz_s2, AW'(msy_s2));
			m10 <= entry(mxy_s2, AW'(msz_s2));
			m11 <= entry(myy_s2, cone);
			m12 <= entry(myz_s2, -AW'(msx_s2));
			m20 <= entry(mxz_s2, -AW'(msy_s2));
			m21 <= entry(myz_s2, AW'(msx_s2));
			m22 <= entry(mzz_s2, cone);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pop) |=> v_s3)
		else $error("waiting result lost while stalled");
	a_nopull: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pop) |-> !q_pop)
		else $error("queue drained while back end stalled");
	a_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pop) |=> ($stable(m00) && $stable(m11) && $stable(m22)))
		else $error("waiting result changed while stalled");

endmodule

>>> hdl/axis_angle_rotation_matrix.sv
// Top level of the axis-angle rotation matrix block.
//
//   channel   direction  handshake         payload
//   input     in         push / full       axis_x axis_y axis_z turn_angle
//   result    out        empty / pop       m00 .. m22
//
// One transaction is accepted per cycle while full is low; each passes through the
// front register, queue write, CORDIC load, 30 CORDIC steps, then the rotate,
// multiply and sum stages. Reset clears all valid flags and the queue pointers
// only. While a result waits unpopped the back end halts; the four-entry queue
// and the front register absorb transactions until full rises.
module axis_angle_rotation_matrix #(
	parameter int FRAC_BITS = 14,
	parameter int ANGLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  axis_x,
	input  logic signed [15:0]  axis_y,
	input  logic signed [15:0]  axis_z,
	input  logic [15:0]         turn_angle,
	input  logic                push,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output logic signed [15:0]  m00,
	output logic signed [15:0]  m01,
	output logic signed [15:0]  m02,
	output logic signed [15:0]  m10,
	output logic signed [15:0]  m11,
	output logic signed [15:0]  m12,
	output logic signed [15:0]  m20,
	output logic signed [15:0]  m21,
	output logic signed [15:0]  m22
);
	import aarm_pkg::*;

	logic  q_push;
	item_t q_wdata;
	logic  q_full;
	logic  q_rvalid;
	item_t q_rdata;
	logic  q_pop;

	aarm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .turn_angle(turn_angle),
		.push(push), .full(full),
		.q_push(q_push), .q_wdata(q_wdata), .q_full(q_full)
	);

	aarm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata), .full(q_full),
		.rvalid(q_rvalid), .rdata(q_rdata), .pop(q_pop)
	);

	aarm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_rvalid(q_rvalid), .q_rdata(q_rdata), .q_pop(q_pop),
		.empty(empty), .pop(pop),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

endmodule
